// ===== src/imm_pkg.sv =====
// Shared types, codes and sequencer program for the integer matrix multiplier.
`timescale 1ns / 1ps

package imm_pkg;

    localparam int DEF_MAX_DIM   = 8;
    localparam int DEF_ELEM_BITS = 16;

    localparam int MODE_W = 2;
    localparam int POS_W  = 3;
    localparam int VAL_W  = 16;
    localparam int DIM_W  = 4;
    localparam int CIDX_W = 2;
    localparam int SUM_W  = 35;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [CIDX_W-1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_A_COL_COUNT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_B_COL_COUNT = 2'd2;

    typedef logic [2:0] t_pc;

    localparam t_pc ST_LOOP  = 3'd0;
    localparam t_pc ST_D1    = 3'd1;
    localparam t_pc ST_D2    = 3'd2;
    localparam t_pc ST_EMIT  = 3'd3;
    localparam t_pc ST_IDLE  = 3'd4;
    localparam t_pc ST_CHECK = 3'd5;
    localparam t_pc ST_ERR   = 3'd6;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_K_MORE,
        JC_NOT_LAST,
        JC_NOT_GO,
        JC_MATCH
    } t_jc;

    typedef struct packed {
        logic rdy;
        logic clr;
        logic issue;
        logic wait_out;
        logic emit;
        logic emit_err;
        t_jc  jc;
        t_pc  target;
    } t_uword;

    typedef struct packed {
        logic we_a;
        logic we_b;
        logic issue;
        logic clr;
    } t_dp_ctrl;

    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        w = '{rdy: 1'b0, clr: 1'b0, issue: 1'b0, wait_out: 1'b0, emit: 1'b0,
              emit_err: 1'b0, jc: JC_NEXT, target: ST_IDLE};
        case (pc)
            ST_LOOP: begin
                w.issue  = 1'b1;
                w.jc     = JC_K_MORE;
                w.target = ST_LOOP;
            end
            ST_D1: begin
                w.jc = JC_NEXT;
            end
            ST_D2: begin
                w.jc = JC_NEXT;
            end
            ST_EMIT: begin
                w.wait_out = 1'b1;
                w.emit     = 1'b1;
                w.jc       = JC_NOT_LAST;
                w.target   = ST_LOOP;
            end
            ST_IDLE: begin
                w.rdy    = 1'b1;
                w.clr    = 1'b1;
                w.jc     = JC_NOT_GO;
                w.target = ST_IDLE;
            end
            ST_CHECK: begin
                w.jc     = JC_MATCH;
                w.target = ST_LOOP;
            end
            ST_ERR: begin
                w.wait_out = 1'b1;
                w.emit_err = 1'b1;
                w.jc       = JC_ALWAYS;
                w.target   = ST_IDLE;
            end
            default: begin
                w.jc     = JC_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/imm_datapath.sv =====
// Element stores and pipelined multiply-accumulate for the matrix multiplier.
`timescale 1ns / 1ps

module imm_datapath
    import imm_pkg::*;
#(
    parameter int MAX_DIM   = DEF_MAX_DIM,
    parameter int ELEM_BITS = DEF_ELEM_BITS,
    parameter int ADDR_W    = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_ctrl                    i_ctrl,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic signed [ELEM_BITS-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]           i_rd_a_addr,
    input  logic [ADDR_W-1:0]           i_rd_b_addr,
    output logic signed [SUM_W-1:0]     o_sum
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int PROD_W = 2 * ELEM_BITS;

    logic signed [ELEM_BITS-1:0] r_a_mem [DEPTH];
    logic signed [ELEM_BITS-1:0] r_b_mem [DEPTH];
    logic signed [ELEM_BITS-1:0] r_a_q;
    logic signed [ELEM_BITS-1:0] r_b_q;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [SUM_W-1:0]     r_acc;
    logic                        r_v1;
    logic                        r_v2;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we_a) begin
            r_a_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.we_b) begin
            r_b_mem[i_wr_addr] <= i_wr_data;
        end
        r_a_q  <= r_a_mem[i_rd_a_addr];
        r_b_q  <= r_b_mem[i_rd_b_addr];
        r_prod <= PROD_W'(r_a_q) * PROD_W'(r_b_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_ctrl.issue;
            r_v2 <= r_v1;
            if (i_ctrl.clr) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= r_acc + SUM_W'(r_prod);
            end
        end
    end

    assign o_sum = r_acc;

endmodule

// ===== src/integer_matrix_multiply_top.sv =====
// Top level of the integer matrix multiplier: config registers, sequencer, result register.
//
//  channel   dir  handshake                  payload
//  s_axis    in   i_s_axis_tvalid/o_..tready tdata{value,col,row}, tuser mode
//  m_axis    out  o_m_axis_tvalid/i_..tready tdata{sum,col,row}, tlast, tuser dim_error
//  cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// Load beats leave the sequencer idle. A compute beat walks R rows, C product columns
// and N inner length through one multiply-accumulate fed by one read port per store;
// a mismatch ends in an error beat. Output stalls hold the sequencer at its emit or
// error step. Reset sets each dimension register to 1; the stores are not cleared.
// Input is ready only while the sequencer idles.
`timescale 1ns / 1ps

module integer_matrix_multiply_top
    import imm_pkg::*;
#(
    parameter int MAX_DIM   = DEF_MAX_DIM,
    parameter int ELEM_BITS = DEF_ELEM_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]    i_s_axis_tdata,   // row[2:0], col[5:3], value[21:6]
    input  logic [MODE_W-1:0]       i_s_axis_tuser,   // mode[1:0]
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]   o_m_axis_tdata,   // out_row[2:0], out_col[5:3], sum[40:6]
    output logic                    o_m_axis_tlast,
    output logic                    o_m_axis_tuser,   // dim_error[0]
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CIDX_W-1:0]       i_cfg_index,
    input  logic [DIM_W-1:0]        i_cfg_data
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int EXT_W  = (ELEM_BITS > VAL_W) ? ELEM_BITS : VAL_W;

    logic [DIM_W-1:0]  r_row_cnt;
    logic [DIM_W-1:0]  r_acol_cnt;
    logic [DIM_W-1:0]  r_bcol_cnt;
    t_pc               r_pc;
    t_pc               n_pc;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic [IDX_W-1:0]  r_k;
    logic [IDX_W-1:0]  n_i;
    logic [IDX_W-1:0]  n_j;
    logic [IDX_W-1:0]  n_k;

    logic                 r_out_valid;
    logic [POS_W-1:0]     r_out_row;
    logic [POS_W-1:0]     r_out_col;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                 r_out_last;
    logic                 r_out_err;

    t_uword              w_uw;
    t_dp_ctrl            w_ctrl;
    logic [MODE_W-1:0]   w_mode;
    logic [POS_W-1:0]    w_row;
    logic [POS_W-1:0]    w_col;
    logic signed [VAL_W-1:0] w_value;
    logic signed [EXT_W-1:0] w_ext;
    logic                w_accept;
    logic                w_in_range;
    logic                w_go;
    logic                w_out_free;
    logic                w_hold;
    logic                w_take;
    logic                w_fire_emit;
    logic                w_fire_err;
    logic                w_last;
    logic [DIM_W-1:0]    w_nr_last;
    logic [DIM_W-1:0]    w_ni_last;
    logic [DIM_W-1:0]    w_nc_last;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [ADDR_W-1:0]   w_rd_a_addr;
    logic [ADDR_W-1:0]   w_rd_b_addr;
    logic signed [SUM_W-1:0] w_sum;

    function automatic logic [DIM_W-1:0] dim_last(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] c;
        if (d == '0) begin
            c = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            c = DIM_W'(MAX_DIM);
        end else begin
            c = d;
        end
        return c - DIM_W'(1);
    endfunction

    assign w_mode  = i_s_axis_tuser;
    assign w_row   = i_s_axis_tdata[2:0];
    assign w_col   = i_s_axis_tdata[5:3];
    assign w_value = i_s_axis_tdata[21:6];
    assign w_ext   = EXT_W'(w_value);

    assign w_uw            = ucode_rom(r_pc);
    assign o_s_axis_tready = w_uw.rdy;
    assign o_cfg_ready     = 1'b1;
    assign w_accept        = i_s_axis_tvalid && w_uw.rdy;
    assign w_in_range      = ({1'b0, w_row} < DIM_W'(MAX_DIM)) &&
                             ({1'b0, w_col} < DIM_W'(MAX_DIM));
    assign w_go            = w_accept && (w_mode == MODE_COMPUTE);

    assign w_nr_last = dim_last(r_row_cnt);
    assign w_ni_last = dim_last(r_acol_cnt);
    assign w_nc_last = dim_last(r_bcol_cnt);
    assign w_last    = (r_i == w_nr_last[IDX_W-1:0]) && (r_j == w_nc_last[IDX_W-1:0]);

    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_hold      = w_uw.wait_out && !w_out_free;
    assign w_fire_emit = w_uw.emit && !w_hold;
    assign w_fire_err  = w_uw.emit_err && !w_hold;

    always_comb begin
        case (w_uw.jc)
            JC_NEXT:     w_take = 1'b0;
            JC_ALWAYS:   w_take = 1'b1;
            JC_K_MORE:   w_take = (r_k != w_ni_last[IDX_W-1:0]);
            JC_NOT_LAST: w_take = !w_last;
            JC_NOT_GO:   w_take = !w_go;
            JC_MATCH:    w_take = (r_row_cnt == r_acol_cnt);
            default:     w_take = 1'b0;
        endcase
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        if (w_uw.clr) begin
            n_i = '0;
            n_j = '0;
            n_k = '0;
        end else if (w_uw.issue) begin
            n_k = r_k + IDX_W'(1);
        end else if (w_fire_emit) begin
            n_k = '0;
            if (r_j == w_nc_last[IDX_W-1:0]) begin
                n_j = '0;
                n_i = r_i + IDX_W'(1);
            end else begin
                n_j = r_j + IDX_W'(1);
            end
        end
    end

    always_comb begin
        w_ctrl.we_a  = w_accept && (w_mode == MODE_LOAD_A) && w_in_range;
        w_ctrl.we_b  = w_accept && (w_mode == MODE_LOAD_B) && w_in_range;
        w_ctrl.issue = w_uw.issue;
        w_ctrl.clr   = w_uw.clr || w_fire_emit;
    end

    assign w_wr_addr   = ADDR_W'(ADDR_W'(w_row) * ADDR_W'(MAX_DIM) + ADDR_W'(w_col));
    assign w_rd_a_addr = ADDR_W'(ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(r_k));
    assign w_rd_b_addr = ADDR_W'(ADDR_W'(r_k) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j));

    imm_datapath #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS),
        .ADDR_W    (ADDR_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_ext[ELEM_BITS-1:0]),
        .i_rd_a_addr (w_rd_a_addr),
        .i_rd_b_addr (w_rd_b_addr),
        .o_sum       (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt   <= DIM_W'(1);
            r_acol_cnt  <= DIM_W'(1);
            r_bcol_cnt  <= DIM_W'(1);
            r_pc        <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ROW_COUNT:   r_row_cnt  <= i_cfg_data;
                    REG_A_COL_COUNT: r_acol_cnt <= i_cfg_data;
                    REG_B_COL_COUNT: r_bcol_cnt <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pc <= n_pc;
            r_i  <= n_i;
            r_j  <= n_j;
            r_k  <= n_k;
            if (w_fire_emit || w_fire_err) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire_emit) begin
            r_out_row  <= POS_W'(r_i);
            r_out_col  <= POS_W'(r_j);
            r_out_sum  <= w_sum;
            r_out_last <= w_last;
            r_out_err  <= 1'b0;
        end else if (w_fire_err) begin
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_sum  <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - SUM_W - 2 * POS_W){1'b0}},
                              r_out_sum, r_out_col, r_out_row};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_err;

endmodule
